// ===== src/bsc_pkg.sv =====
// ----------------------------------------------------------------------------
// Bitmap stream compaction: shared types and constants
// Lane count, value width and the item and result records.
// ----------------------------------------------------------------------------
package bsc_pkg;

   localparam int LANES    = 8;
   localparam int VALUE_W  = 32;
   localparam int FILL_W   = $clog2(LANES);
   localparam int SLOT_W   = $clog2(LANES) + 1;
   localparam int CAT_W    = $clog2(2 * LANES);
   localparam int TOTAL_W  = 32;
   localparam int QDEPTH   = 4;
   localparam int QCOUNT_W = $clog2(QDEPTH) + 1;

   localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

   typedef struct packed {
      logic                            final_group;
      logic [3:0]                      rows_in_group;
      logic [LANES-1:0]                valid_bits;
      logic [LANES-1:0][VALUE_W-1:0]   values;
   } item_type;

   typedef struct packed {
      logic [TOTAL_W-1:0]              kept_total;
      logic                            end_of_column;
      logic [SLOT_W-1:0]               slots_used;
      logic [LANES-1:0][VALUE_W-1:0]   outs;
   } result_type;

   typedef struct packed {
      logic       valid0;
      logic       valid1;
      result_type res0;
      result_type res1;
   } merge_out_type;

endpackage

// ===== src/bsc_merge.sv =====
// ----------------------------------------------------------------------------
// Bitmap stream compaction: compact and merge
// Packs kept lanes behind the held values, splits off a full group and
// builds the closing result; owns the holding buffer and the kept count.
// ----------------------------------------------------------------------------
module bsc_merge (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  bsc_pkg::item_type      item,
   output bsc_pkg::merge_out_type mo
);

   logic [bsc_pkg::LANES-1:0][bsc_pkg::VALUE_W-1:0]     hold_ff, hold_in;
   logic [bsc_pkg::FILL_W-1:0]                          fill_ff, fill_in;
   logic [bsc_pkg::TOTAL_W-1:0]                         count_ff, count_in;

   logic [bsc_pkg::LANES-1:0]                           mask;
   logic [bsc_pkg::LANES-1:0][bsc_pkg::CAT_W-1:0]       dst;
   logic [2*bsc_pkg::LANES-1:0][bsc_pkg::VALUE_W-1:0]   cat;
   logic [bsc_pkg::SLOT_W-1:0]                          kept;
   logic [bsc_pkg::CAT_W-1:0]                           sum;
   logic                                                wrap;
   logic [bsc_pkg::FILL_W-1:0]                          new_fill;
   logic [bsc_pkg::TOTAL_W:0]                           count_sum;
   logic [bsc_pkg::TOTAL_W-1:0]                         new_count;
   bsc_pkg::result_type                                 full_res, close_res;

   always_comb begin
      for (int j = 0; j < bsc_pkg::LANES; j++) begin
         mask[j] = item.valid_bits[j] && (4'(j) < item.rows_in_group);
      end
      kept = '0;
      for (int j = 0; j < bsc_pkg::LANES; j++) begin
         dst[j] = bsc_pkg::CAT_W'(fill_ff) + bsc_pkg::CAT_W'(kept);
         kept   = kept + bsc_pkg::SLOT_W'(mask[j]);
      end
      for (int i = 0; i < 2 * bsc_pkg::LANES; i++) begin
         cat[i] = '0;
         if (i < bsc_pkg::LANES) begin
            if (bsc_pkg::CAT_W'(i) < bsc_pkg::CAT_W'(fill_ff)) begin
               cat[i] = hold_ff[i];
            end
         end
         for (int j = 0; j < bsc_pkg::LANES; j++) begin
            if (mask[j] && dst[j] == bsc_pkg::CAT_W'(i)) begin
               cat[i] = item.values[j];
            end
         end
      end
      sum      = bsc_pkg::CAT_W'(fill_ff) + bsc_pkg::CAT_W'(kept);
      wrap     = sum[bsc_pkg::CAT_W-1];
      new_fill = sum[bsc_pkg::FILL_W-1:0];
      for (int i = 0; i < bsc_pkg::LANES; i++) begin
         hold_in[i] = wrap ? cat[i + bsc_pkg::LANES] : cat[i];
      end
      count_sum = {1'b0, count_ff} + (bsc_pkg::TOTAL_W + 1)'(kept);
      new_count = count_sum[bsc_pkg::TOTAL_W] ? bsc_pkg::TOTAL_MAX
                                              : count_sum[bsc_pkg::TOTAL_W-1:0];

      for (int i = 0; i < bsc_pkg::LANES; i++) begin
         full_res.outs[i] = cat[i];
         close_res.outs[i] = (bsc_pkg::FILL_W'(i) < new_fill) ? hold_in[i] : '0;
      end
      full_res.slots_used     = bsc_pkg::SLOT_W'(bsc_pkg::LANES);
      full_res.end_of_column  = 1'b0;
      full_res.kept_total     = new_count;
      close_res.slots_used    = bsc_pkg::SLOT_W'(new_fill);
      close_res.end_of_column = 1'b1;
      close_res.kept_total    = new_count;

      mo.valid0 = wrap || item.final_group;
      mo.valid1 = wrap && item.final_group;
      mo.res0   = wrap ? full_res : close_res;
      mo.res1   = close_res;

      fill_in  = item.final_group ? '0 : new_fill;
      count_in = item.final_group ? '0 : new_count;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         count_ff <= '0;
      end else if (advance) begin
         fill_ff  <= fill_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         hold_ff <= hold_in;
      end
   end

endmodule

// ===== src/bsc_out_queue.sv =====
// ----------------------------------------------------------------------------
// Bitmap stream compaction: result queue
// Shift queue that takes up to two results a cycle and offers the oldest.
// ----------------------------------------------------------------------------
module bsc_out_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  bsc_pkg::merge_out_type mo,
   input  logic                   pop,
   output logic                   room,
   output logic                   head_valid,
   output bsc_pkg::result_type    head
);

   bsc_pkg::result_type [bsc_pkg::QDEPTH-1:0] q_ff, q_in;
   logic [bsc_pkg::QCOUNT_W-1:0]              count_ff, count_in;
   logic [bsc_pkg::QCOUNT_W-1:0]              base;
   logic                                      push0, push1;

   always_comb begin
      push0 = push && mo.valid0;
      push1 = push && mo.valid1;
      base  = count_ff - bsc_pkg::QCOUNT_W'(pop);
      for (int i = 0; i < bsc_pkg::QDEPTH; i++) begin
         if (pop && i < bsc_pkg::QDEPTH - 1) begin
            q_in[i] = q_ff[i + 1];
         end else begin
            q_in[i] = q_ff[i];
         end
         if (push0 && base == bsc_pkg::QCOUNT_W'(i)) begin
            q_in[i] = mo.res0;
         end
         if (push1 && base + 1'b1 == bsc_pkg::QCOUNT_W'(i)) begin
            q_in[i] = mo.res1;
         end
      end
      count_in = base + bsc_pkg::QCOUNT_W'(push0) + bsc_pkg::QCOUNT_W'(push1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

   assign room       = count_ff <= bsc_pkg::QCOUNT_W'(bsc_pkg::QDEPTH - 2);
   assign head_valid = count_ff != '0;
   assign head       = q_ff[0];

endmodule

// ===== src/bitmap_stream_compaction.sv =====
// ----------------------------------------------------------------------------
// Bitmap stream compaction
// Columnar filter: keeps the lanes of each group marked in the validity
// byte and below its row count, and repacks them into dense groups of eight.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  carries one group of eight row values per word with its validity
//          byte and row count; req_tlast marks the last group of a column.
//   rsp_*  carries dense groups; rsp_tlast marks the closing word of a
//          column, which holds the remainder and the final kept total.
//   A group is registered on input and merged into the holding buffer when
//   the queue has room; its result words are registered in the result queue
//   before they reach rsp_*.
//   One group is taken per cycle while the queue has room. A group that both
//   fills the buffer and closes the column yields two words; the output side
//   moves one word per cycle while rsp_tready is high, so the queue holds both.
//   A four-word result queue parts the two sides: req_tready stays high
//   while the queue has room for two more words, whatever rsp_tready does.
//   Reset empties the input register, the queue and the holding buffer and
//   clears the kept count; no clearing pass is needed.
// ----------------------------------------------------------------------------
module bitmap_stream_compaction (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [271:0] req_tdata,  // value_0..value_7, valid_bits, rows_in_group, pad
   input  logic         req_tlast,  // final_group
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [295:0] rsp_tdata,  // out_0..out_7, slots_used, kept_total, pad
   output logic         rsp_tlast   // end_of_column
);

   localparam int VAL_BITS = bsc_pkg::LANES * bsc_pkg::VALUE_W;

   bsc_pkg::item_type      in_ff, in_in;
   logic                   in_valid_ff, in_valid_in;
   logic                   accept, advance, room;
   bsc_pkg::merge_out_type mo;
   bsc_pkg::result_type    head;

   assign advance    = in_valid_ff && room;
   assign req_tready = !in_valid_ff || advance;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      in_in.values        = req_tdata[VAL_BITS-1:0];
      in_in.valid_bits    = req_tdata[VAL_BITS +: bsc_pkg::LANES];
      in_in.rows_in_group = req_tdata[VAL_BITS + bsc_pkg::LANES +: 4];
      in_in.final_group   = req_tlast;
      in_valid_in         = accept || (in_valid_ff && !advance);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_ff <= in_in;
      end
   end

   bsc_merge u_merge (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (in_ff),
      .mo      (mo)
   );

   bsc_out_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (advance),
      .mo         (mo),
      .pop        (rsp_tvalid && rsp_tready),
      .room       (room),
      .head_valid (rsp_tvalid),
      .head       (head)
   );

   assign rsp_tdata = {4'b0, head.kept_total, head.slots_used, head.outs};
   assign rsp_tlast = head.end_of_column;

endmodule

// ===== src/bsc_checker.sv =====
// ----------------------------------------------------------------------------
// Bitmap stream compaction: port checker
// Watches the result channel for stalls, group sizes and reset behaviour.
// ----------------------------------------------------------------------------
module bsc_checker (
   input logic         clock,
   input logic         reset,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [295:0] rsp_tdata,
   input logic         rsp_tlast
);

   logic [3:0] slots;
   assign slots = rsp_tdata[259:256];

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result word dropped or changed while stalled");

   a_mid_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> slots == 4'd8)
      else $error("non-closing word is not a full group");

   a_slots_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> slots <= 4'd8)
      else $error("slot count beyond lane count");

   a_empty_close: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast && slots == 4'd0 |-> rsp_tdata[255:0] == 256'd0)
      else $error("empty closing word carries data");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid straight after reset");

endmodule

bind bitmap_stream_compaction bsc_checker u_bsc_checker (.*);

// ===== test/tb_bitmap_stream_compaction.sv =====
// ----------------------------------------------------------------------------
// Bitmap stream compaction testbench
// Sends groups of eight row values with validity bytes and row counts, packs
// the kept values into dense groups in a scoreboard of its own and checks
// every result word, field by field, under varying source and sink stalls.
// ----------------------------------------------------------------------------
module tb_bitmap_stream_compaction;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int REQ_W      = 272;
   localparam int RSP_W      = 296;
   localparam int SLOTS_LSB  = bsc_pkg::LANES * bsc_pkg::VALUE_W;
   localparam int TOTAL_LSB  = SLOTS_LSB + bsc_pkg::SLOT_W;
   localparam int REPORT_CAP = 100;

   typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} value_fill_type;

   class compaction_board_type;
      bsc_pkg::result_type              expected_words[$];
      logic [bsc_pkg::VALUE_W-1:0]      hold [bsc_pkg::LANES];
      int unsigned                      hold_fill;
      logic [bsc_pkg::TOTAL_W-1:0]      kept_count;
      int unsigned                      errors;
      int unsigned                      words_seen;
      int unsigned                      columns_closed;

      function new();
         hold_fill      = 0;
         kept_count     = '0;
         errors         = 0;
         words_seen     = 0;
         columns_closed = 0;
      endfunction

      function int unsigned pending();
         return expected_words.size();
      endfunction

      // pack the kept lanes and queue the words this group produces
      function void note_group(bsc_pkg::item_type g);
         int unsigned                                     rows;
         logic [bsc_pkg::LANES-1:0][bsc_pkg::VALUE_W-1:0] full_group;
         bit                                              have_full;
         bsc_pkg::result_type                             r;
         rows       = (g.rows_in_group > bsc_pkg::LANES) ? bsc_pkg::LANES : g.rows_in_group;
         have_full  = 0;
         full_group = '0;
         for (int j = 0; j < rows; j++) begin
            if (g.valid_bits[j]) begin
               hold[hold_fill] = g.values[j];
               hold_fill++;
               if (kept_count != bsc_pkg::TOTAL_MAX)
                  kept_count++;
               if (hold_fill == bsc_pkg::LANES) begin
                  for (int k = 0; k < bsc_pkg::LANES; k++)
                     full_group[k] = hold[k];
                  have_full = 1;
                  hold_fill = 0;
               end
            end
         end
         if (have_full) begin
            r.outs          = full_group;
            r.slots_used    = bsc_pkg::SLOT_W'(bsc_pkg::LANES);
            r.end_of_column = 1'b0;
            r.kept_total    = kept_count;
            expected_words.push_back(r);
         end
         if (g.final_group) begin
            for (int k = 0; k < bsc_pkg::LANES; k++)
               r.outs[k] = (k < hold_fill) ? hold[k] : '0;
            r.slots_used    = bsc_pkg::SLOT_W'(hold_fill);
            r.end_of_column = 1'b1;
            r.kept_total    = kept_count;
            expected_words.push_back(r);
            hold_fill  = 0;
            kept_count = '0;
         end
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            errors++;
            if (errors <= REPORT_CAP)
               $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
         end
      endfunction

      function void check_word(logic [RSP_W-1:0] data, logic last);
         bsc_pkg::result_type want;
         words_seen++;
         if (expected_words.size() == 0) begin
            errors++;
            if (errors <= REPORT_CAP)
               $display("%0t ns: result word with none expected, actual %h last %b",
                        $time, data, last);
            return;
         end
         want = expected_words.pop_front();
         for (int k = 0; k < bsc_pkg::LANES; k++)
            compare_field($sformatf("out_%0d", k), want.outs[k],
                          data[k*bsc_pkg::VALUE_W +: bsc_pkg::VALUE_W]);
         compare_field("slots_used", 32'(want.slots_used),
                       32'(data[SLOTS_LSB +: bsc_pkg::SLOT_W]));
         compare_field("end_of_column", 32'(want.end_of_column), 32'(last));
         compare_field("kept_total", want.kept_total, data[TOTAL_LSB +: bsc_pkg::TOTAL_W]);
         if (last)
            columns_closed++;
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata;
   logic             req_tlast;
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [RSP_W-1:0] rsp_tdata;
   logic             rsp_tlast;

   compaction_board_type board = new();
   int unsigned          send_idle_pct;
   int unsigned          rsp_stall_pct;
   int unsigned          groups_sent;

   bitmap_stream_compaction u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_word(rsp_tdata, rsp_tlast);
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   function automatic bsc_pkg::item_type make_group(logic [7:0] bits, logic [3:0] rows,
                                                    logic fin, value_fill_type fill);
      bsc_pkg::item_type g;
      g.valid_bits    = bits;
      g.rows_in_group = rows;
      g.final_group   = fin;
      for (int j = 0; j < bsc_pkg::LANES; j++) begin
         case (fill)
            FILL_ZERO: g.values[j] = '0;
            FILL_ONES: g.values[j] = '1;
            default:   g.values[j] = $urandom();
         endcase
      end
      return g;
   endfunction

   task automatic send_group(input bsc_pkg::item_type g);
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, g.rows_in_group, g.valid_bits, g.values};
      req_tlast  <= g.final_group;
      do
         @(posedge clock);
      while (!req_tready);
      board.note_group(g);
      groups_sent++;
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do
            @(posedge clock);
         while ($urandom_range(99) < send_idle_pct);
      end
   endtask

   // hold off until every queued word has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0)
         @(posedge clock);
   endtask

   task automatic run_directed();
      send_group(make_group(8'hFF, 4'd8,  1'b1, FILL_ONES));
      send_group(make_group(8'h00, 4'd8,  1'b1, FILL_RANDOM));
      send_group(make_group(8'hFF, 4'd0,  1'b1, FILL_RANDOM));
      send_group(make_group(8'hFF, 4'd15, 1'b0, FILL_ZERO));
      send_group(make_group(8'hFF, 4'd9,  1'b0, FILL_RANDOM));
      send_group(make_group(8'h07, 4'd3,  1'b0, FILL_RANDOM));
      send_group(make_group(8'hFF, 4'd5,  1'b0, FILL_RANDOM));
      send_group(make_group(8'hFF, 4'd2,  1'b0, FILL_RANDOM));
      send_group(make_group(8'h80, 4'd8,  1'b0, FILL_RANDOM));
      send_group(make_group(8'h01, 4'd1,  1'b1, FILL_ONES));
      send_group(make_group(8'h55, 4'd8,  1'b0, FILL_RANDOM));
      send_group(make_group(8'hAA, 4'd8,  1'b0, FILL_RANDOM));
      send_group(make_group(8'hFF, 4'd8,  1'b1, FILL_RANDOM));
      send_group(make_group(8'hF0, 4'd4,  1'b1, FILL_RANDOM));
      send_group(make_group(8'hFF, 4'd7,  1'b0, FILL_ONES));
      send_group(make_group(8'hFF, 4'd8,  1'b1, FILL_ZERO));
      send_group(make_group(8'hC3, 4'd12, 1'b1, FILL_RANDOM));
      send_group(make_group(8'h00, 4'd0,  1'b0, FILL_RANDOM));
      send_group(make_group(8'h3C, 4'd6,  1'b1, FILL_ONES));
   endtask

   function automatic logic [7:0] pick_bits();
      int unsigned sel;
      sel = $urandom_range(9);
      case (sel)
         5, 6:    return 8'hFF;
         7:       return 8'h00;
         8:       return 8'h01 << $urandom_range(7);
         9:       return 8'($urandom() & $urandom());
         default: return 8'($urandom());
      endcase
   endfunction

   task automatic send_column();
      int unsigned    len;
      logic           fin;
      logic [3:0]     rows;
      value_fill_type fill;
      len = ($urandom_range(9) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 12);
      for (int i = 0; i < len; i++) begin
         fin = (i == len - 1);
         if (fin)
            rows = 4'(($urandom_range(9) < 7) ? $urandom_range(1, 8) : $urandom_range(0, 15));
         else
            rows = 4'(($urandom_range(99) < 85) ? 8 : $urandom_range(0, 15));
         case ($urandom_range(19))
            0:       fill = FILL_ZERO;
            1:       fill = FILL_ONES;
            default: fill = FILL_RANDOM;
         endcase
         send_group(make_group(pick_bits(), rows, fin, fill));
      end
   endtask

   initial begin
      int unsigned phase_idle [4];
      int unsigned phase_stall [4];
      int unsigned phase_end;
      phase_idle  = '{0, 53, 0, 21};
      phase_stall = '{0, 0, 53, 21};
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      groups_sent   = 0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tlast  <= 1'b0;
      rsp_tready <= 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();
      drain();

      for (int p = 0; p < 4; p++) begin
         send_idle_pct = phase_idle[p];
         rsp_stall_pct = phase_stall[p];
         phase_end     = groups_sent + 485;
         while (groups_sent < phase_end)
            send_column();
         drain();
      end

      rsp_stall_pct = 0;
      repeat (10) @(posedge clock);
      $display("Sent %0d groups in %0d columns; checked %0d result words.",
               groups_sent, board.columns_closed, board.words_seen);
      $display("Covered short and oversized row counts, empty flushes and stall phases.");
      if (board.errors == 0 && board.pending() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Timeout with %0d result words outstanding.", board.pending());
      $display("Verification failed");
      $finish;
   end

endmodule

// ===== bitmap_stream_compaction.f =====
src/bsc_pkg.sv
src/bsc_merge.sv
src/bsc_out_queue.sv
src/bitmap_stream_compaction.sv
src/bsc_checker.sv
test/tb_bitmap_stream_compaction.sv
